// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/efdcc_pkg.sv
// ----------------------------------------------------------------------------
// efdcc_pkg
// Constants, register indexes and CRC helper for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package efdcc_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLAG_CODE   = 2'd0,
        CFG_ESCAPE_CODE = 2'd1
    } cfg_idx_t;

    localparam logic [7:0]  FLAG_CODE_RST   = 8'hC0;
    localparam logic [7:0]  ESCAPE_CODE_RST = 8'hDB;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h8408;

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = c_in;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ b[k];
            c  = {1'b0, c[15:1]};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/escaped_frame_deframer_crc_check_top.sv
// Path from input beat: input register, byte-wide CRC update, result register, result beat.
// Throughput: one line byte per cycle, unless a result beat waits on m_axis_tready.
// A byte that yields no result still takes one slot in the input register.
// Reset (rst_n low, async): frame state, counters and config return to defaults; no clear pass.
// ----------------------------------------------------------------------------
// escaped_frame_deframer_crc_check_top
// Byte-stuffed frame deframer with CRC-16 (0x8408 reflected) check and
// end-of-frame status beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module escaped_frame_deframer_crc_check_top
    import efdcc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // config write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,

    // line bytes in
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] line_byte

    // content / status beats out
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [23:0]               m_axis_tdata,   // [7:0] content_byte, [8] crc_good,
                                                      // [9] short_frame, [17:10] error_total,
                                                      // [23:18] zero
    output logic                      m_axis_tuser    // [0] is_status
);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [7:0] flag_code_reg;
    logic [7:0] escape_code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_code_reg   <= FLAG_CODE_RST;
            escape_code_reg <= ESCAPE_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FLAG_CODE:   flag_code_reg   <= cfg_data;
                CFG_ESCAPE_CODE: escape_code_reg <= cfg_data;
                default:         ;  // unmapped index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       out_vld_reg;
    logic       proceed;

    // The byte in the input register is processed whenever the result
    // register is free or being drained this cycle.
    assign proceed       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // ------------------------------------------------------------------
    // deframer state
    // ------------------------------------------------------------------
    logic        inside_reg,  inside_next;
    logic        esc_reg,     esc_next;
    logic [15:0] crc_reg,     crc_next;
    logic [7:0]  held0_reg,   held0_next;
    logic [7:0]  held1_reg,   held1_next;
    logic [1:0]  cnt_reg,     cnt_next;
    logic [7:0]  fail_reg,    fail_next;

    // result candidate
    logic        emit;
    logic [7:0]  res_byte;
    logic        res_status;
    logic        res_good;
    logic        res_short;

    logic        is_flag;
    logic        is_esc;
    logic        full;
    logic        crc_match;
    logic [15:0] crc_fed;

    assign is_flag   = (in_byte_reg == flag_code_reg);
    assign is_esc    = (in_byte_reg == escape_code_reg);
    assign full      = cnt_reg[1];
    assign crc_match = (held0_reg == crc_reg[7:0]) && (held1_reg == crc_reg[15:8]);
    assign crc_fed   = crc_feed(crc_reg, held0_reg);

    always_comb
    begin
        inside_next = inside_reg;
        esc_next    = esc_reg;
        crc_next    = crc_reg;
        held0_next  = held0_reg;
        held1_next  = held1_reg;
        cnt_next    = cnt_reg;
        fail_next   = fail_reg;
        emit        = 1'b0;
        res_byte    = 8'd0;
        res_status  = 1'b0;
        res_good    = 1'b0;
        res_short   = 1'b0;

        if (!inside_reg)
        begin
            // hunting for the opening flag
            if (is_flag)
            begin
                inside_next = 1'b1;
                esc_next    = 1'b0;
                crc_next    = CRC_INIT;
                cnt_next    = 2'd0;
            end
        end
        else if (!esc_reg && is_flag)
        begin
            // closing flag; back-to-back flags keep the frame open
            if (cnt_reg != 2'd0)
            begin
                res_good    = full && crc_match;
                res_short   = !full;
                res_status  = 1'b1;
                emit        = 1'b1;
                inside_next = 1'b0;
                esc_next    = 1'b0;
                if (!res_good)
                begin
                    fail_next = fail_reg + 8'd1;
                end
            end
        end
        else if (!esc_reg && is_esc)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            // content byte (literal after escape)
            esc_next = 1'b0;
            if (full)
            begin
                res_byte   = held0_reg;
                emit       = 1'b1;
                crc_next   = crc_fed;
                held0_next = held1_reg;
                held1_next = in_byte_reg;
            end
            else
            begin
                if (cnt_reg[0])
                begin
                    held1_next = in_byte_reg;
                end
                else
                begin
                    held0_next = in_byte_reg;
                end
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            esc_reg    <= 1'b0;
            crc_reg    <= CRC_INIT;
            cnt_reg    <= 2'd0;
            fail_reg   <= 8'd0;
        end
        else if (proceed)
        begin
            inside_reg <= inside_next;
            esc_reg    <= esc_next;
            crc_reg    <= crc_next;
            cnt_reg    <= cnt_next;
            fail_reg   <= fail_next;
        end
    end

    // held bytes are only read once cnt_reg says they were written
    always_ff @(posedge clk)
    begin
        if (proceed)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [23:0] out_data_reg;
    logic        out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_axis_tready)
        begin
            out_vld_reg <= proceed && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && emit)
        begin
            out_data_reg <= {6'd0, fail_next, res_short, res_good, res_byte};
            out_user_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an escape can only be pending inside a frame
    `ASSERT_IMP(a_esc_inside, clk, rst_n, esc_reg, inside_reg)
    // a status beat is never both good and short, and carries no content
    `ASSERT_IMP(a_status_flags, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        !(m_axis_tdata[8] && m_axis_tdata[9]) && (m_axis_tdata[7:0] == 8'd0))
    // the shown error count tracks the live counter while a beat waits
    `ASSERT_IMP(a_err_total, clk, rst_n, m_axis_tvalid, m_axis_tdata[17:10] == fail_reg)
    // a content beat only leaves once the delay line was full
    `ASSERT_NXT(a_fwd_full, clk, rst_n, proceed && emit && !res_status, cnt_reg[1])

endmodule

`default_nettype wire
